// ===== sv/assert_macros.svh =====
// Assertion macros shared by the divider RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sid_pkg.sv =====
// Types and constants for the signed 32-bit divider.
package sid_pkg;

	localparam int DW    = 32;
	localparam int CNT_W = $clog2(DW);

	localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};

	// Status from the shift-subtract unit to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} sid_stat_t;

endpackage

// ===== sv/sid_core.sv =====
// Iterative restoring shift-subtract unit: one quotient bit per cycle.
module sid_core
	import sid_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] quo,
	output sid_stat_t     stat
);

	localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    num_q;  // dividend bits shift out the top, quotient bits in the bottom
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;

	logic [DW:0] shifted;
	logic [DW:0] diff;
	logic        take;

	// Shift in the next dividend bit and trial-subtract the divisor.
	assign shifted = {rem_q, num_q[DW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign take    = !diff[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], take};
			rem_q <= take ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign quo       = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== sv/signed_int32_divider.sv =====
// Top level of the signed 32-bit truncating divider.
//
//  channel  | dir | tdata                         | tuser
//  ---------+-----+-------------------------------+-------------------------------------
//  s_axis   | in  | [31:0] dividend, [63:32] divisor | none
//  m_axis   | out | [31:0] quotient               | [0] overflowed, [1] divide_by_zero
//
// Nonzero divisor: the magnitudes load on the accepting edge; the unit then makes one
// shift-subtract pass per quotient bit, then its done strobe; the fixup step sets the sign.
// Zero divisor: skip the unit and go straight to fixup, which loads the output register.
// s_axis_tready is high only in idle, so no new beat is taken until the last leaves fixup.
// The result waits in an output register while the next beat is taken; if that register is
// still full when the next result is ready, hold in the fixup step.
// arst_n clears the sequencer and the output valid; data registers keep no reset.
module signed_int32_divider
	import sid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] dividend, [63:32] divisor
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] quotient
	output logic [1:0]  m_axis_tuser    // [0] overflowed, [1] divide_by_zero
);

`include "assert_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIX  = 3'b100
	} state_t;

	state_t state_q;

	logic [DW-1:0] dividend;
	logic [DW-1:0] divisor;
	logic [DW-1:0] mag_a;
	logic [DW-1:0] mag_b;
	logic          in_beat;
	logic          div_zero;
	logic          start;

	logic          neg_q;
	logic          dz_q;

	logic [DW-1:0] core_quo;
	sid_stat_t     core_stat;

	logic          out_free;
	logic [DW-1:0] res_quo;
	logic          res_ovf;

	logic          m_valid_q;
	logic [DW-1:0] m_quo_q;
	logic          m_ovf_q;
	logic          m_dz_q;

	assign dividend = s_axis_tdata[DW-1:0];
	assign divisor  = s_axis_tdata[2*DW-1:DW];

	// Work on magnitudes; the minimum value maps to 2^31 as an unsigned number.
	assign mag_a = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b = divisor[DW-1]  ? (~divisor  + 1'b1) : divisor;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign div_zero      = (divisor == '0);
	assign start         = in_beat && !div_zero;

	sid_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (mag_a),
		.den    (mag_b),
		.quo    (core_quo),
		.stat   (core_stat)
	);

	// Sequencer: accept, iterate, then fix up the sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= div_zero ? ST_FIX : ST_RUN;
					end
				end
				ST_RUN: begin
					if (core_stat.done) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the sign and the zero-divisor case with the beat.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			neg_q <= dividend[DW-1] ^ divisor[DW-1];
			dz_q  <= div_zero;
		end
	end

	// Final result: a zero divisor gives QMAX; saturate a positive quotient past the signed range,
	// negate when the operand signs differ.
	always_comb begin
		res_ovf = 1'b0;
		priority if (dz_q) begin
			res_quo = QMAX;
		end else if (!neg_q && core_quo[DW-1]) begin
			res_quo = QMAX;
			res_ovf = 1'b1;
		end else if (neg_q) begin
			res_quo = ~core_quo + 1'b1;
		end else begin
			res_quo = core_quo;
		end
	end

	// Output register: load when empty or being drained this cycle.
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_FIX && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIX && out_free) begin
			m_quo_q <= res_quo;
			m_ovf_q <= res_ovf;
			m_dz_q  <= dz_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_quo_q;
	assign m_axis_tuser  = {m_dz_q, m_ovf_q};

	`SID_ASSERT_NOW(a_done_in_run, core_stat.done, state_q == ST_RUN,
		"shift-subtract unit finished outside the run state")
	`SID_ASSERT_NEXT(a_zero_skips_core, in_beat && div_zero,
		state_q == ST_FIX && !core_stat.busy, "zero divisor did not go straight to fixup")
	`SID_ASSERT_NOW(a_flags_exclusive, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]),
		"overflow and divide-by-zero raised on the same beat")
	`SID_ASSERT_NOW(a_dz_saturates, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == QMAX,
		"divide-by-zero beat without saturated quotient")

endmodule
